// ===== rtl/cascaded_biquad_iir_filter_assert.svh =====
// Assertion macros for the cascaded biquad filter.
// No dependencies; included by the top level.
`ifndef CASCADED_BIQUAD_IIR_FILTER_ASSERT_SVH
`define CASCADED_BIQUAD_IIR_FILTER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CBQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbq assertion failed");

// next-cycle implication, disabled during reset
`define CBQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbq assertion failed");

`endif

// ===== rtl/cbq_pkg.sv =====
// Package for the cascaded biquad filter: widths, codes, sequencer types.
// No dependencies.
`timescale 1ns / 1ps

package cbq_pkg;

    localparam int MAX_SECTIONS = 4;
    localparam int NUM_COEFS    = 6;
    localparam int NUM_HIST     = 4;
    localparam int COEF_DEPTH   = MAX_SECTIONS * NUM_COEFS;
    localparam int HIST_DEPTH   = MAX_SECTIONS * NUM_HIST;
    localparam int COEF_AW      = $clog2(COEF_DEPTH);
    localparam int HIST_AW      = $clog2(HIST_DEPTH);
    localparam int SEC_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 20;
    localparam int IDX_W    = 2;
    localparam int SEL_W    = 3;
    localparam int CFG_W    = 3;

    localparam int MUL_B_W     = 20;
    localparam int PROD_W      = COEF_W + MUL_B_W;
    localparam int CENTER_W    = 37;
    localparam int CENTER_LO_W = 19;
    localparam int CENTER_HI_W = CENTER_W - CENTER_LO_W;
    localparam int ACC_W       = 60;
    localparam int FB_SHIFT    = 16;
    localparam int ROUND_SHIFT = 32;

    localparam int OP_W      = 3;
    localparam int NUM_OPS   = 7;
    localparam int STEP_W    = 4;
    localparam logic [STEP_W-1:0] STEP_WR_X1 = STEP_W'(5);
    localparam logic [STEP_W-1:0] STEP_WR_X2 = STEP_W'(6);
    localparam logic [STEP_W-1:0] STEP_WR_Y2 = STEP_W'(7);
    localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(8);

    localparam logic MODE_FILTER = 1'b0;
    localparam logic MODE_COEF   = 1'b1;

    typedef enum logic [SEL_W-1:0] {
        CS_B0, CS_B1, CS_B2, CS_A0, CS_A1, CS_A2
    } t_coef_sel;

    typedef enum logic [1:0] {
        HS_X1, HS_X2, HS_Y1, HS_Y2
    } t_hist_slot;

    typedef enum logic [OP_W-1:0] {
        OP_B0, OP_B1, OP_B2, OP_A1, OP_A2, OP_A0_LO, OP_A0_HI
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE, ST_RUN, ST_DRAIN
    } t_state;

    typedef struct packed {
        logic vld;
        t_op  op;
    } t_tag;

    function automatic t_coef_sel op_coef(input t_op op);
        case (op)
            OP_B0:    return CS_B0;
            OP_B1:    return CS_B1;
            OP_B2:    return CS_B2;
            OP_A1:    return CS_A1;
            OP_A2:    return CS_A2;
            OP_A0_LO: return CS_A0;
            OP_A0_HI: return CS_A0;
            default:  return CS_B0;
        endcase
    endfunction

    function automatic t_hist_slot op_hist(input t_op op);
        case (op)
            OP_B1:   return HS_X1;
            OP_B2:   return HS_X2;
            OP_A1:   return HS_Y1;
            OP_A2:   return HS_Y2;
            default: return HS_X1;
        endcase
    endfunction

    function automatic logic op_reads_hist(input t_op op);
        case (op)
            OP_B1, OP_B2, OP_A1, OP_A2: return 1'b1;
            default:                    return 1'b0;
        endcase
    endfunction

endpackage

// ===== rtl/cbq_in_if.sv =====
// Request channel of the biquad cascade: valid, ready and one request.
// Depends on cbq_pkg.
`timescale 1ns / 1ps

interface cbq_in_if import cbq_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [IDX_W-1:0]           section_index;
    logic [SEL_W-1:0]           coeff_select;
    logic signed [COEF_W-1:0]   coeff_value;

    modport source (
        output valid, mode, sample_in, section_index, coeff_select, coeff_value,
        input  ready
    );
    modport sink (
        input  valid, mode, sample_in, section_index, coeff_select, coeff_value,
        output ready
    );
endinterface

// ===== rtl/cbq_out_if.sv =====
// Result channel of the biquad cascade: valid, ready and one filtered sample.
// Depends on cbq_pkg.
`timescale 1ns / 1ps

interface cbq_out_if import cbq_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       saturated;

    modport source (
        output valid, sample_out, saturated,
        input  ready
    );
    modport sink (
        input  valid, sample_out, saturated,
        output ready
    );
endinterface

// ===== rtl/cascaded_biquad_iir_filter.sv =====
// Cascaded direct form 1 biquad filter; coefficient and history memories, one multiplier.
// Depends on cbq_pkg, cbq_in_if, cbq_out_if, cascaded_biquad_iir_filter_assert.svh.
// Sample request: each active section runs its steps through the shared multiplier; the result
// is registered at the output, and no new request is taken until it has been loaded there.
// Coefficient request: stored when taken, no result. Synchronous reset: control cleared,
// active_sections = 1, both memories read as zero through per-entry valid bits.
`timescale 1ns / 1ps

`include "cascaded_biquad_iir_filter_assert.svh"

module cascaded_biquad_iir_filter import cbq_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    cbq_in_if.sink           i_in,
    cbq_out_if.source        o_out
);

    logic [CFG_W-1:0] r_active_sections;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [SEC_W-1:0]  r_sec, n_sec;
    logic [SEC_W-1:0]  r_last_sec, w_last_sec;
    logic [SEC_W-1:0]  r_fsec;
    logic              r_pend, n_pend;

    logic signed [SAMPLE_W-1:0] r_x;
    logic                       r_sat;
    t_tag                       r_t1, r_t2;

    logic signed [COEF_W-1:0]   r_coef_mem [COEF_DEPTH];
    logic [COEF_DEPTH-1:0]      r_coef_vld;
    logic signed [COEF_W-1:0]   r_coef_q;
    logic                       r_coef_qv;
    logic signed [SAMPLE_W-1:0] r_hist_mem [HIST_DEPTH];
    logic [HIST_DEPTH-1:0]      r_hist_vld;
    logic signed [SAMPLE_W-1:0] r_hist_q;
    logic                       r_hist_qv;

    logic signed [SAMPLE_W-1:0] r_hx1, r_hy1;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [CENTER_W-1:0] r_center;
    logic signed [ACC_W-1:0]    r_acc;

    logic                       r_out_vld;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic                       r_out_sat;

    logic                       w_in_acc;
    logic                       w_out_free;
    logic                       w_out_load;
    logic                       w_issue;
    t_op                        w_op;
    logic                       w_coef_we;
    logic [COEF_AW-1:0]         w_coef_waddr;
    logic [COEF_AW-1:0]         w_coef_raddr;
    logic                       w_hist_re;
    logic [HIST_AW-1:0]         w_hist_raddr;
    logic                       w_hist_we;
    logic [HIST_AW-1:0]         w_hist_waddr;
    logic signed [SAMPLE_W-1:0] w_hist_wdata;

    logic signed [COEF_W-1:0]   w_mul_a;
    logic signed [MUL_B_W-1:0]  w_mul_b;
    logic signed [SAMPLE_W-1:0] w_hist_eff;
    logic signed [ACC_W-1:0]    w_prod_ext;
    logic signed [ACC_W:0]      w_biased;
    logic [ACC_W-ROUND_SHIFT-SAMPLE_W+1:0] w_y_hi;
    logic                       w_clip;
    logic signed [SAMPLE_W-1:0] w_y;

    assign i_in.ready   = (r_state == ST_IDLE);
    assign w_in_acc     = i_in.valid && i_in.ready;
    assign w_out_free   = !r_out_vld || o_out.ready;

    assign o_out.valid      = r_out_vld;
    assign o_out.sample_out = r_out_sample;
    assign o_out.saturated  = r_out_sat;

    // clamp the section count to 1 .. MAX_SECTIONS
    always_comb begin
        if (r_active_sections == '0) begin
            w_last_sec = '0;
        end else if (32'(r_active_sections) > MAX_SECTIONS) begin
            w_last_sec = SEC_W'(MAX_SECTIONS - 1);
        end else begin
            w_last_sec = SEC_W'(r_active_sections - 1'b1);
        end
    end

    // coefficient request: drop unknown selects and sections
    assign w_coef_we    = w_in_acc && (i_in.mode == MODE_COEF)
                          && (32'(i_in.coeff_select) < NUM_COEFS)
                          && (32'(i_in.section_index) < MAX_SECTIONS);
    assign w_coef_waddr = COEF_AW'(32'(i_in.section_index) * NUM_COEFS
                          + 32'(i_in.coeff_select));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_sections <= CFG_W'(1);
        end else if (i_cfg_wr_en) begin
            r_active_sections <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_sec   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_sec   <= n_sec;
            r_pend  <= n_pend;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_sec        = r_sec;
        n_pend       = 1'b0;
        w_issue      = 1'b0;
        w_op         = t_op'(r_step[OP_W-1:0]);
        w_out_load   = 1'b0;
        w_hist_we    = 1'b0;
        w_hist_waddr = HIST_AW'(32'(r_sec) * NUM_HIST + 32'(HS_X1));
        w_hist_wdata = r_x;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (i_in.mode == MODE_FILTER)) begin
                    n_state = ST_RUN;
                    n_step  = '0;
                    n_sec   = '0;
                end
            end
            ST_RUN: begin
                w_issue = (32'(r_step) < NUM_OPS);
                case (r_step)
                    STEP_WR_X1: begin
                        w_hist_we    = 1'b1;
                    end
                    STEP_WR_X2: begin
                        w_hist_we    = 1'b1;
                        w_hist_waddr = HIST_AW'(32'(r_sec) * NUM_HIST + 32'(HS_X2));
                        w_hist_wdata = r_hx1;
                    end
                    STEP_WR_Y2: begin
                        w_hist_we    = 1'b1;
                        w_hist_waddr = HIST_AW'(32'(r_sec) * NUM_HIST + 32'(HS_Y2));
                        w_hist_wdata = r_hy1;
                    end
                    default: begin
                    end
                endcase
                if (r_step == STEP_LAST) begin
                    n_pend = 1'b1;
                    if (r_sec == r_last_sec) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_sec  = r_sec + 1'b1;
                        n_step = '0;
                    end
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end else begin
                    n_pend = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        // finish of a section: store its output as y1
        if (r_pend) begin
            w_hist_we    = 1'b1;
            w_hist_waddr = HIST_AW'(32'(r_fsec) * NUM_HIST + 32'(HS_Y1));
            w_hist_wdata = w_y;
        end
    end

    assign w_coef_raddr = COEF_AW'(32'(r_sec) * NUM_COEFS + 32'(op_coef(w_op)));
    assign w_hist_re    = w_issue && op_reads_hist(w_op);
    assign w_hist_raddr = HIST_AW'(32'(r_sec) * NUM_HIST + 32'(op_hist(w_op)));

    always_ff @(posedge i_clk) begin
        if (w_coef_we) begin
            r_coef_mem[w_coef_waddr] <= i_in.coeff_value;
        end
        if (w_issue) begin
            r_coef_q <= r_coef_mem[w_coef_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_hist_we) begin
            r_hist_mem[w_hist_waddr] <= w_hist_wdata;
        end
        if (w_hist_re) begin
            r_hist_q <= r_hist_mem[w_hist_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_vld <= '0;
            r_hist_vld <= '0;
            r_coef_qv  <= 1'b0;
            r_hist_qv  <= 1'b0;
        end else begin
            if (w_coef_we) begin
                r_coef_vld[w_coef_waddr] <= 1'b1;
            end
            if (w_hist_we) begin
                r_hist_vld[w_hist_waddr] <= 1'b1;
            end
            if (w_issue) begin
                r_coef_qv <= r_coef_vld[w_coef_raddr];
            end
            if (w_hist_re) begin
                r_hist_qv <= r_hist_vld[w_hist_raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1 <= '0;
            r_t2 <= '0;
        end else begin
            r_t1 <= '{vld: w_issue, op: w_op};
            r_t2 <= r_t1;
        end
    end

    assign w_mul_a    = r_coef_qv ? r_coef_q : '0;
    assign w_hist_eff = r_hist_qv ? r_hist_q : '0;

    always_comb begin
        case (r_t1.op)
            OP_B0: begin
                w_mul_b = {{(MUL_B_W-SAMPLE_W){r_x[SAMPLE_W-1]}}, r_x};
            end
            OP_B1, OP_B2, OP_A1, OP_A2: begin
                w_mul_b = {{(MUL_B_W-SAMPLE_W){w_hist_eff[SAMPLE_W-1]}}, w_hist_eff};
            end
            OP_A0_LO: begin
                w_mul_b = {{(MUL_B_W-CENTER_LO_W){1'b0}}, r_center[CENTER_LO_W-1:0]};
            end
            OP_A0_HI: begin
                w_mul_b = {{(MUL_B_W-CENTER_HI_W){r_center[CENTER_W-1]}},
                           r_center[CENTER_W-1:CENTER_LO_W]};
            end
            default: begin
                w_mul_b = '0;
            end
        endcase
    end

    // multiply stage; hold x1 and y1 for the history shift
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        if (r_t1.vld && (r_t1.op == OP_B1)) begin
            r_hx1 <= w_hist_eff;
        end
        if (r_t1.vld && (r_t1.op == OP_A1)) begin
            r_hy1 <= w_hist_eff;
        end
    end

    assign w_prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    // accumulate stage
    always_ff @(posedge i_clk) begin
        if (r_t2.vld) begin
            case (r_t2.op)
                OP_B0:    r_center <= $signed(r_prod[CENTER_W-1:0]);
                OP_B1:    r_center <= r_center + $signed(r_prod[CENTER_W-1:0]);
                OP_B2:    r_center <= r_center + $signed(r_prod[CENTER_W-1:0]);
                OP_A1:    r_acc    <= -(w_prod_ext <<< FB_SHIFT);
                OP_A2:    r_acc    <= r_acc - (w_prod_ext <<< FB_SHIFT);
                OP_A0_LO: r_acc    <= r_acc + w_prod_ext;
                OP_A0_HI: r_acc    <= r_acc + (w_prod_ext <<< CENTER_LO_W);
                default: begin
                end
            endcase
        end
    end

    // round half up, then clip to the sample range
    assign w_biased = $signed({r_acc[ACC_W-1], r_acc})
                      + $signed({{(ACC_W-ROUND_SHIFT+1){1'b0}}, 1'b1,
                                 {(ROUND_SHIFT-1){1'b0}}});
    assign w_y_hi   = w_biased[ACC_W:ROUND_SHIFT+SAMPLE_W-1];
    assign w_clip   = !((&w_y_hi) || !(|w_y_hi));

    always_comb begin
        if (w_clip) begin
            w_y = w_biased[ACC_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                  : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else begin
            w_y = w_biased[ROUND_SHIFT+SAMPLE_W-1:ROUND_SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_in.mode == MODE_FILTER)) begin
            r_x        <= i_in.sample_in;
            r_sat      <= 1'b0;
            r_last_sec <= w_last_sec;
        end else if (r_pend) begin
            r_x   <= w_y;
            r_sat <= r_sat || w_clip;
        end
        if ((r_state == ST_RUN) && (r_step == STEP_LAST)) begin
            r_fsec <= r_sec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_sample <= w_y;
            r_out_sat    <= r_sat || w_clip;
        end
    end

    `CBQ_ASSERT_IMPLIES(a_hist_no_overlap, i_clk, i_rst_n, w_hist_re && w_hist_we, w_hist_raddr != w_hist_waddr)
    `CBQ_ASSERT_IMPLIES(a_pipe_empty_at_finish, i_clk, i_rst_n, r_pend, !r_t1.vld && !r_t2.vld)
    `CBQ_ASSERT_IMPLIES(a_sec_in_range, i_clk, i_rst_n, r_state == ST_RUN, r_sec <= r_last_sec)
    `CBQ_ASSERT_NEXT(a_coef_req_no_busy, i_clk, i_rst_n, w_in_acc && (i_in.mode == MODE_COEF), r_state == ST_IDLE)

endmodule
